>>> rtl/assert_macros.svh
// assertion macros for the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/kdrq_pkg.sv
// package: types, constants and codes of the keyed delay-release queue
`timescale 1ns / 1ps
package kdrq_pkg;

  localparam int DEPTH     = 64;
  localparam int AW        = $clog2(DEPTH);
  localparam int MAX_BATCH = 16;
  localparam int BW        = $clog2(MAX_BATCH + 1);

  localparam logic [AW:0] EMPTY_MARK = (AW + 1)'(DEPTH);

  // configuration register indexes
  localparam logic CFG_WAIT_TICKS  = 1'b0;
  localparam logic CFG_MAX_RUNNING = 1'b1;

  // command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_DUP      = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_REMOVED  = 3'd3,
    KIND_NOTFOUND = 3'd4,
    KIND_DISPATCH = 3'd5,
    KIND_NONE     = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    CLS_TICK,
    CLS_ADD,
    CLS_REMOVE,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NONE,
    S_TICK_RD,
    S_TICK_CHK,
    S_SCAN,
    S_ADD,
    S_RM_RD,
    S_RM_DO
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [15:0] payload;
    logic [9:0]  running;
    logic        running_unknown;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] out_key;
    logic [15:0] out_payload;
    logic        last;
  } out_res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic     valid;
    cls_t     cls;
    in_item_t item;
  } req_t;

endpackage

>>> rtl/kdrq_ram.sv
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module kdrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/kdrq_front.sv
// front part: accepts items, classifies the command, two-entry queue to the back
`timescale 1ns / 1ps
module kdrq_front import kdrq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output req_t     req,
  input  logic     pop
);

  cls_t     q_cls  [2];
  in_item_t q_item [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push;
  cls_t       cls_in;

  // command decode
  always_comb begin
    unique case (in_item.cmd)
      CMD_TICK:   cls_in = CLS_TICK;
      CMD_ADD:    cls_in = CLS_ADD;
      CMD_REMOVE: cls_in = CLS_REMOVE;
      default:    cls_in = CLS_OTHER;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_cls[wptr]  <= cls_in;
      q_item[wptr] <= in_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign req.valid = (count != 2'd0);
  assign req.cls   = q_cls[rptr];
  assign req.item  = q_item[rptr];

endmodule

>>> rtl/kdrq_back.sv
// back part: table walk, linked arrival order, dispatch and result register
`timescale 1ns / 1ps
module kdrq_back import kdrq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  output logic        pop,
  input  logic [15:0] wait_ticks,
  input  logic [9:0]  max_running,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_res
);

  state_t state, state_next;

  in_item_t    cur;
  cls_t        cur_cls;
  logic [31:0] now_count;
  logic [AW:0] head, tail;
  logic        valid_bits [DEPTH];
  logic [AW:0] cnt;
  logic          chk_v;
  logic          chk_vb;
  logic [AW-1:0] chk_idx;
  logic          match_v, free_v;
  logic [AW-1:0] match_idx, free_idx;
  logic [BW-1:0] n;
  logic          pend_v;
  logic [15:0]   pend_key, pend_pay;

  logic [AW-1:0] raddr;
  logic [15:0]   key_rd, pay_rd;
  logic [31:0]   stamp_rd;
  logic [AW-1:0] next_rd, prev_rd;
  logic          add_we;
  logic          next_we, prev_we;
  logic [AW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;

  logic     out_free, due, can, go, step_ok;
  logic     scan_hit, scan_end;
  logic     do_disp, do_add, do_rm;
  logic     res_load;
  out_res_t res_data;
  logic     s_is_head, s_is_tail;

  // entry stores
  kdrq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_key (
    .clk, .we(add_we), .waddr(free_idx), .wdata(cur.key), .raddr, .rdata(key_rd));
  kdrq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_pay (
    .clk, .we(add_we), .waddr(free_idx), .wdata(cur.payload), .raddr, .rdata(pay_rd));
  kdrq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stamp (
    .clk, .we(add_we), .waddr(free_idx), .wdata(now_count), .raddr, .rdata(stamp_rd));
  kdrq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next (
    .clk, .we(next_we), .waddr(next_waddr), .wdata(next_wdata), .raddr,
    .rdata(next_rd));
  kdrq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev (
    .clk, .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata), .raddr,
    .rdata(prev_rd));

  // status terms
  assign out_free  = !out_valid || !out_stall;
  assign due       = (now_count - stamp_rd) >= {16'd0, wait_ticks};
  assign can       = !cur.running_unknown && (n < BW'(MAX_BATCH)) &&
                     (head != EMPTY_MARK) &&
                     (({1'b0, cur.running} + 11'(n)) <= {1'b0, max_running});
  assign go        = can && due;
  assign step_ok   = !((pend_v || !go) && !out_free);
  assign scan_hit  = chk_v && chk_vb && (key_rd == cur.key);
  assign scan_end  = (cnt == EMPTY_MARK) && !chk_v;
  assign s_is_head = (head == {1'b0, match_idx});
  assign s_is_tail = (tail == {1'b0, match_idx});

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state, memory control and result loading
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    raddr      = cnt[AW-1:0];
    add_we     = 1'b0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = tail[AW-1:0];
    next_wdata = free_idx;
    prev_waddr = free_idx;
    prev_wdata = tail[AW-1:0];
    do_disp    = 1'b0;
    do_add     = 1'b0;
    do_rm      = 1'b0;
    res_load   = 1'b0;
    res_data   = '{kind: KIND_NONE, out_key: 16'd0, out_payload: 16'd0, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          pop = 1'b1;
          unique case (req.cls)
            CLS_TICK:   state_next = S_TICK_RD;
            CLS_ADD:    state_next = S_SCAN;
            CLS_REMOVE: state_next = S_SCAN;
            default:    state_next = S_NONE;
          endcase
        end
      end
      S_NONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK_RD: begin
        raddr      = head[AW-1:0];
        state_next = S_TICK_CHK;
      end
      S_TICK_CHK: begin
        raddr = head[AW-1:0];
        if (step_ok) begin
          if (pend_v) begin
            res_load = 1'b1;
            res_data = '{kind: KIND_DISPATCH, out_key: pend_key,
                         out_payload: pend_pay, last: !go};
          end else if (!go) begin
            res_load = 1'b1;
          end
          do_disp    = go;
          state_next = go ? S_TICK_RD : S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = (cur_cls == CLS_ADD) ? S_ADD : S_RM_RD;
        end else if (scan_end) begin
          state_next = (cur_cls == CLS_ADD) ? S_ADD : S_RM_DO;
        end
      end
      S_ADD: begin
        if (out_free) begin
          res_load = 1'b1;
          res_data.out_key = cur.key;
          if (match_v) begin
            res_data.kind = KIND_DUP;
          end else if (!free_v) begin
            res_data.kind = KIND_FULL;
          end else begin
            res_data.kind = KIND_ADDED;
            do_add  = 1'b1;
            add_we  = 1'b1;
            prev_we = 1'b1;
            next_we = (head != EMPTY_MARK);
          end
          state_next = S_IDLE;
        end
      end
      S_RM_RD: begin
        raddr      = match_idx;
        state_next = S_RM_DO;
      end
      S_RM_DO: begin
        raddr = match_idx;
        if (out_free) begin
          res_load = 1'b1;
          res_data.out_key = cur.key;
          res_data.kind    = match_v ? KIND_REMOVED : KIND_NOTFOUND;
          if (match_v) begin
            do_rm      = 1'b1;
            next_waddr = prev_rd;
            next_wdata = next_rd;
            prev_waddr = next_rd;
            prev_wdata = prev_rd;
            next_we    = !s_is_head;
            prev_we    = !s_is_head && !s_is_tail;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // current item
  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= req.item;
      cur_cls <= req.cls;
    end
  end

  // time counter
  always_ff @(posedge clk) begin
    if (rst) begin
      now_count <= 32'd0;
    end else if (pop && req.cls == CLS_TICK) begin
      now_count <= now_count + 32'd1;
    end
  end

  // table walk pipeline and search results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      chk_v   <= 1'b0;
      match_v <= 1'b0;
      free_v  <= 1'b0;
    end else if (pop) begin
      cnt     <= '0;
      chk_v   <= 1'b0;
      match_v <= 1'b0;
      free_v  <= 1'b0;
    end else if (state == S_SCAN) begin
      chk_v   <= (cnt != EMPTY_MARK) && !scan_hit;
      chk_vb  <= valid_bits[cnt[AW-1:0]];
      chk_idx <= cnt[AW-1:0];
      if (cnt != EMPTY_MARK) cnt <= cnt + 1'b1;
      if (scan_hit) begin
        match_v   <= 1'b1;
        match_idx <= chk_idx;
      end
      if (chk_v && !chk_vb && !free_v) begin
        free_v   <= 1'b1;
        free_idx <= chk_idx;
      end
    end
  end

  // dispatch batch count and held dispatch result
  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= '0;
      pend_v <= 1'b0;
    end else if (pop) begin
      n      <= '0;
      pend_v <= 1'b0;
    end else if (state == S_TICK_CHK && step_ok) begin
      pend_v   <= go;
      pend_key <= key_rd;
      pend_pay <= pay_rd;
      if (go) n <= n + 1'b1;
    end
  end

  // valid bits and arrival order ends
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= EMPTY_MARK;
      tail <= EMPTY_MARK;
      for (int i = 0; i < DEPTH; i++) valid_bits[i] <= 1'b0;
    end else begin
      if (do_disp) begin
        valid_bits[head[AW-1:0]] <= 1'b0;
        if (head == tail) begin
          head <= EMPTY_MARK;
          tail <= EMPTY_MARK;
        end else begin
          head <= {1'b0, next_rd};
        end
      end
      if (do_add) begin
        valid_bits[free_idx] <= 1'b1;
        if (head == EMPTY_MARK) head <= {1'b0, free_idx};
        tail <= {1'b0, free_idx};
      end
      if (do_rm) begin
        valid_bits[match_idx] <= 1'b0;
        if (s_is_head) begin
          head <= s_is_tail ? EMPTY_MARK : {1'b0, next_rd};
          if (s_is_tail) tail <= EMPTY_MARK;
        end else if (s_is_tail) begin
          tail <= {1'b0, prev_rd};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_res <= res_data;
  end

endmodule

>>> rtl/keyed_delay_release_queue.sv
// top level: configuration registers, front classifier and back engine
// a tick reads the entry stores at the queue head through their registered read port,
//   once per dispatch; add and remove walk over the key store one slot per cycle
// throughput: one item at a time in the back part; the front holds two more items
// reset: synchronous, active high; empties the table and clears time and registers
`timescale 1ns / 1ps
module keyed_delay_release_queue import kdrq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] wait_ticks;
  logic [9:0]  max_running;
  req_t        req;
  logic        pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks  <= 16'd0;
      max_running <= 10'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAIT_TICKS:  wait_ticks  <= cfg_data;
        CFG_MAX_RUNNING: max_running <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  kdrq_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item, .req, .pop);

  kdrq_back u_back (
    .clk, .rst, .req, .pop, .wait_ticks, .max_running,
    .out_valid, .out_stall, .out_res);

endmodule

>>> rtl/kdrq_check.sv
// port checker for the keyed delay-release queue and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kdrq_check import kdrq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_stall,
  input out_res_t out_res
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_res))
  // kinds stay within the defined codes
  `ASSERT_IMP(a_kind_range, clk, rst, out_valid, out_res.kind <= KIND_NONE)
  // only dispatch results can be followed by more results of the same item
  `ASSERT_IMP(a_single_last, clk, rst, out_valid && out_res.kind != KIND_DISPATCH,
    out_res.last)
  // payload goes out on dispatch only
  `ASSERT_IMP(a_payload_zero, clk, rst, out_valid && out_res.kind != KIND_DISPATCH,
    out_res.out_payload == 16'd0)

endmodule

bind keyed_delay_release_queue kdrq_check u_kdrq_check (.*);

>>> verif/tb_top.sv
// testbench for the keyed delay-release queue: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
module tb_top;
  import kdrq_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_res_t    out_res;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  keyed_delay_release_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // shadow state of the queue
  logic [15:0] m_wait;
  logic [9:0]  m_maxrun;
  logic        m_valid [DEPTH];
  logic [15:0] m_key [DEPTH];
  logic [15:0] m_pay [DEPTH];
  logic [31:0] m_stamp [DEPTH];
  int          m_order [$];
  logic [31:0] m_now;

  out_res_t expected_q [$];
  int       n_errors;
  int       n_results;
  int       n_dispatch;
  int       n_full;
  bit       hold_off;

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input out_res_t got, input out_res_t exp);
    n_errors++;
    $display("mismatch %s: got kind=%0d key=%h pay=%h last=%0d, ",
             what, got.kind, got.out_key, got.out_payload, got.last,
             "exp kind=%0d key=%h pay=%h last=%0d",
             exp.kind, exp.out_key, exp.out_payload, exp.last);
  endtask

  function automatic out_res_t mk(input kind_t k, input logic [15:0] key,
                                  input logic [15:0] pay, input logic lst);
    out_res_t r;
    r.kind = k;
    r.out_key = key;
    r.out_payload = pay;
    r.last = lst;
    return r;
  endfunction

  function automatic int lookup_key(input logic [15:0] key);
    for (int i = 0; i < DEPTH; i++)
      if (m_valid[i] && m_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void drop_slot(input int s);
    for (int i = 0; i < m_order.size(); i++)
      if (m_order[i] == s) begin
        m_order.delete(i);
        break;
      end
    m_valid[s] = 1'b0;
  endfunction

  // predict results of one accepted item and queue them
  function automatic void predict_results(input in_item_t it);
    int s;
    int n;
    n = 0;
    s = -1;
    case (it.cmd)
      CMD_TICK: begin
        m_now = m_now + 1;
        if (!it.running_unknown) begin
          while (n < MAX_BATCH && m_order.size() > 0 &&
                 ({22'd0, it.running} + n) <= {22'd0, m_maxrun}) begin
            s = m_order[0];
            if ((m_now - m_stamp[s]) < {16'd0, m_wait}) break;
            expected_q.push_back(mk(KIND_DISPATCH, m_key[s], m_pay[s], 1'b0));
            drop_slot(s);
            n++;
          end
        end
        if (n == 0) expected_q.push_back(mk(KIND_NONE, 16'd0, 16'd0, 1'b1));
        else expected_q[$].last = 1'b1;
      end
      CMD_ADD: begin
        if (lookup_key(it.key) >= 0) begin
          expected_q.push_back(mk(KIND_DUP, it.key, 16'd0, 1'b1));
        end else begin
          for (int i = 0; i < DEPTH; i++)
            if (!m_valid[i]) begin
              s = i;
              break;
            end
          if (s < 0) begin
            expected_q.push_back(mk(KIND_FULL, it.key, 16'd0, 1'b1));
          end else begin
            m_valid[s] = 1'b1;
            m_key[s] = it.key;
            m_pay[s] = it.payload;
            m_stamp[s] = m_now;
            m_order.push_back(s);
            expected_q.push_back(mk(KIND_ADDED, it.key, 16'd0, 1'b1));
          end
        end
      end
      CMD_REMOVE: begin
        s = lookup_key(it.key);
        if (s < 0) begin
          expected_q.push_back(mk(KIND_NOTFOUND, it.key, 16'd0, 1'b1));
        end else begin
          drop_slot(s);
          expected_q.push_back(mk(KIND_REMOVED, it.key, 16'd0, 1'b1));
        end
      end
      default: expected_q.push_back(mk(KIND_NONE, 16'd0, 16'd0, 1'b1));
    endcase
  endfunction

  // result checker and receiver stall pattern
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected", out_res, '0);
        end else begin
          if (out_res !== expected_q[0]) report_mismatch("field", out_res, expected_q[0]);
          if (out_res.kind == KIND_DISPATCH) n_dispatch++;
          if (out_res.kind == KIND_FULL) n_full++;
          void'(expected_q.pop_front());
        end
      end
      // stall in runs of its own; long hold-off forces back-pressure
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one item through the input handshake; valid stays up for a following item
  task automatic send_item(input in_item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_results(it);
  endtask

  int burst_left;
  task automatic send_paced(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_item(it);
  endtask

  task automatic drain_then_settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WAIT_TICKS) m_wait = val;
    else m_maxrun = val[9:0];
    @(posedge clk);
  endtask

  function automatic in_item_t item_of(input logic [1:0] c, input logic [15:0] k,
                                       input logic [15:0] p, input logic [9:0] r,
                                       input logic u);
    in_item_t it;
    it.cmd = c;
    it.key = k;
    it.payload = p;
    it.running = r;
    it.running_unknown = u;
    return it;
  endfunction

  // directed rows; a check flag marks rows with a typed-in result
  typedef struct {
    in_item_t it;
    bit       chk;
    out_res_t res;
  } row_t;

  row_t rows [$];
  in_item_t it;
  logic [15:0] key_pool [16];

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WAIT_TICKS;
    cfg_data = '0;
    hold_off = 1'b0;
    n_errors = 0;
    n_results = 0;
    n_dispatch = 0;
    n_full = 0;
    burst_left = 0;
    m_wait = '0;
    m_maxrun = '0;
    m_now = '0;
    for (int i = 0; i < DEPTH; i++) begin
      m_valid[i] = 1'b0;
      m_key[i] = '0;
      m_pay[i] = '0;
      m_stamp[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, immediate release
    write_reg(CFG_WAIT_TICKS, 16'd0);
    write_reg(CFG_MAX_RUNNING, 16'd1023);
    rows.push_back('{item_of(CMD_TICK, 16'h0, 16'h0, 10'd0, 1'b0), 1,
                     mk(KIND_NONE, 16'h0, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_REMOVE, 16'hffff, 16'h0, 10'd0, 1'b0), 1,
                     mk(KIND_NOTFOUND, 16'hffff, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_ADD, 16'h0000, 16'hffff, 10'd0, 1'b0), 1,
                     mk(KIND_ADDED, 16'h0000, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_ADD, 16'hffff, 16'h0000, 10'd1023, 1'b1), 1,
                     mk(KIND_ADDED, 16'hffff, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_ADD, 16'h0000, 16'h1234, 10'd0, 1'b0), 1,
                     mk(KIND_DUP, 16'h0000, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_UNUSED, 16'hffff, 16'hffff, 10'd1023, 1'b1), 1,
                     mk(KIND_NONE, 16'h0, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_TICK, 16'hffff, 16'hffff, 10'd0, 1'b1), 1,
                     mk(KIND_NONE, 16'h0, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_TICK, 16'h0, 16'h0, 10'd1023, 1'b0), 0, '0});
    rows.push_back('{item_of(CMD_TICK, 16'h0, 16'h0, 10'd0, 1'b0), 0, '0});
    rows.push_back('{item_of(CMD_ADD, 16'h5a5a, 16'ha5a5, 10'd0, 1'b0), 0, '0});
    rows.push_back('{item_of(CMD_REMOVE, 16'h5a5a, 16'h0, 10'd0, 1'b0), 1,
                     mk(KIND_REMOVED, 16'h5a5a, 16'h0, 1'b1)});
    rows.push_back('{item_of(CMD_TICK, 16'h0, 16'h0, 10'd0, 1'b0), 0, '0});
    // typed rows replace the prediction so the block is held to them directly
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].chk) begin
        if (expected_q[$] !== rows[i].res)
          report_mismatch("table", expected_q[$], rows[i].res);
        expected_q[$] = rows[i].res;
      end
    end
    drain_then_settle();

    // fill the table to the brim, then one more to see rejection
    write_reg(CFG_WAIT_TICKS, 16'hffff);
    write_reg(CFG_MAX_RUNNING, 16'd0);
    for (int i = 0; i <= DEPTH; i++)
      send_item(item_of(CMD_ADD, 16'(32'h8000 + i), 16'($urandom_range(0, 65535)),
                        10'd0, 1'b0));
    send_item(item_of(CMD_TICK, 16'h0, 16'h0, 10'd0, 1'b0));
    drain_then_settle();

    // long receiver hold-off while releasing in batches
    write_reg(CFG_WAIT_TICKS, 16'd0);
    write_reg(CFG_MAX_RUNNING, 16'd5);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_item(item_of(CMD_TICK, 16'h0, 16'h0, 10'($urandom_range(0, 6)), 1'b0));
    join
    drain_then_settle();

    // random phases, each with its own setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin write_reg(CFG_WAIT_TICKS, 16'd1); write_reg(CFG_MAX_RUNNING, 16'd1023); end
        1: begin write_reg(CFG_WAIT_TICKS, 16'd3); write_reg(CFG_MAX_RUNNING, 16'd8); end
        2: begin write_reg(CFG_WAIT_TICKS, 16'd0); write_reg(CFG_MAX_RUNNING, 16'd0); end
        default: begin
          write_reg(CFG_WAIT_TICKS, 16'($urandom_range(0, 5)));
          write_reg(CFG_MAX_RUNNING, 16'($urandom_range(0, 40)));
        end
      endcase
      foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(0, 65535));
      for (int i = 0; i < 14; i++) begin
        it.cmd = 2'($urandom_range(0, 9) < 4 ? CMD_ADD :
                    ($urandom_range(0, 5) < 4 ? CMD_TICK : CMD_REMOVE));
        if ($urandom_range(0, 30) == 0) it.cmd = CMD_UNUSED;
        it.key = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                             : key_pool[$urandom_range(0, 15)];
        it.payload = 16'($urandom_range(0, 65535));
        it.running = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, 4));
        it.running_unknown = ($urandom_range(0, 7) == 0);
        send_paced(it);
      end
      // flush what is left
      for (int i = 0; i < 4; i++)
        send_paced(item_of(CMD_TICK, 16'($urandom_range(0, 65535)), 16'h0, 10'd0, 1'b0));
      drain_then_settle();
    end

    $display("covered %0d results, %0d dispatches, %0d full rejections, long hold-off",
             n_results, n_dispatch, n_full);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/kdrq_pkg.sv
rtl/kdrq_ram.sv
rtl/kdrq_front.sv
rtl/kdrq_back.sv
rtl/keyed_delay_release_queue.sv
rtl/kdrq_check.sv
verif/tb_top.sv
